FILE: hw/rtl/ipow_pkg.sv
// ipow_pkg: shared types and codes for the integer power unit.
// No dependencies; imported by ipow_mul and integer_power_by_squaring_unit.
package ipow_pkg;

	// Partial-product steps of the shared multiplier
	typedef logic [1:0] mul_step_t;
	localparam mul_step_t MUL_STEP_LL  = 2'd0;
	localparam mul_step_t MUL_STEP_LH  = 2'd1;
	localparam mul_step_t MUL_STEP_HL  = 2'd2;
	localparam mul_step_t MUL_STEP_FIN = 2'd3;

	// Result status codes
	typedef logic status_t;
	localparam status_t STATUS_OK      = 1'b0;
	localparam status_t STATUS_INVALID = 1'b1;

	// Sequencer state codes
	typedef logic [1:0] seq_state_t;
	localparam seq_state_t S_IDLE  = 2'd0;
	localparam seq_state_t S_CHECK = 2'd1;
	localparam seq_state_t S_MUL   = 2'd2;
	localparam seq_state_t S_SQR   = 2'd3;

endpackage

FILE: hw/rtl/ipow_mul.sv
// ipow_mul: low-half wrapping multiplier, VALUE_WIDTH x VALUE_WIDTH -> VALUE_WIDTH.
// One half-width multiplier reused over three partial products. Uses ipow_pkg.
module ipow_mul #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [VALUE_WIDTH-1:0] op_a,
	input  logic [VALUE_WIDTH-1:0] op_b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] product
);
	import ipow_pkg::*;

	localparam int HALF = (VALUE_WIDTH + 1) / 2;

	logic                   run_q;
	logic                   done_q;
	mul_step_t              step_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [VALUE_WIDTH-1:0] sum_q;
	logic [2*HALF-1:0]      prod_s1;

	logic [HALF-1:0]        a_lo, a_hi, b_lo, b_hi;
	logic [HALF-1:0]        opx, opy;
	logic [2*HALF-1:0]      prod_full;
	logic [VALUE_WIDTH-1:0] prod_shifted;

	assign a_lo = a_q[HALF-1:0];
	assign b_lo = b_q[HALF-1:0];
	assign a_hi = HALF'(a_q[VALUE_WIDTH-1:HALF]);
	assign b_hi = HALF'(b_q[VALUE_WIDTH-1:HALF]);

	// cross terms land at bit HALF; the high*high term is beyond the word
	always_comb begin
		case (step_q)
			MUL_STEP_LL: begin
				opx = a_lo;
				opy = b_lo;
			end
			MUL_STEP_LH: begin
				opx = a_lo;
				opy = b_hi;
			end
			MUL_STEP_HL: begin
				opx = a_hi;
				opy = b_lo;
			end
			default: begin
				opx = '0;
				opy = '0;
			end
		endcase
		prod_full = opx * opy;
	end

	assign prod_shifted = {prod_s1[VALUE_WIDTH-HALF-1:0], {HALF{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= MUL_STEP_LL;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= MUL_STEP_LL;
			end else if (run_q) begin
				step_q <= step_q + mul_step_t'(1);
				if (step_q == MUL_STEP_FIN) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= op_a;
			b_q <= op_b;
		end
		if (run_q) begin
			prod_s1 <= prod_full;
			case (step_q)
				MUL_STEP_LL:  sum_q <= sum_q;
				MUL_STEP_LH:  sum_q <= prod_s1[VALUE_WIDTH-1:0];
				MUL_STEP_HL:  sum_q <= sum_q + prod_shifted;
				MUL_STEP_FIN: sum_q <= sum_q + prod_shifted;
				default:      sum_q <= sum_q;
			endcase
		end
	end

	assign done    = done_q;
	assign product = sum_q;

endmodule

FILE: hw/rtl/integer_power_by_squaring_unit.sv
// integer_power_by_squaring_unit: base^exponent modulo 2^VALUE_WIDTH by binary squaring.
// Top level: exponent-bit sequencer around one shared ipow_mul. Uses ipow_pkg.
//
//   channel   | signals                          | flow
//   ----------+----------------------------------+------------------------------
//   request   | start, busy, base_value,exponent | taken when start & !busy
//   result    | done, power_result, status       | one-cycle strobe, no backpressure
//
// A request with exponent 0 or negative is answered from the decision state, with no product.
// Otherwise each exponent bit passes through the decision state plus the products
// on the shared multiplier (3 partial products through one half-width multiplier);
// a set bit costs acc*sq and, while higher bits remain, sq*sq; a clear bit costs sq*sq.
// busy stays high from the taken request until the result strobe.
// Reset: arst_n clears the sequencer, the multiplier control and the strobe.
// The receiver cannot stall: done is high for exactly one cycle per request.
module integer_power_by_squaring_unit #(
	parameter int VALUE_WIDTH    = 64,
	parameter int EXPONENT_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [VALUE_WIDTH-1:0]    base_value,
	input  logic [EXPONENT_WIDTH-1:0] exponent,
	output logic                      done,
	output logic [VALUE_WIDTH-1:0]    power_result,
	output logic                      status
);
	import ipow_pkg::*;

	localparam int REM_W = EXPONENT_WIDTH - 1;

	seq_state_t             state_q;
	logic                   neg_q;       // exponent was negative
	logic [VALUE_WIDTH-1:0] acc_q;       // running product
	logic [VALUE_WIDTH-1:0] sq_q;        // base^(2^k)
	logic [REM_W-1:0]       rem_q;       // exponent bits still to use
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] result_q;
	status_t                status_q;

	logic                   mul_go;
	logic [VALUE_WIDTH-1:0] mul_a;
	logic                   mul_done;
	logic [VALUE_WIDTH-1:0] mul_prod;
	logic                   take;
	logic [REM_W-1:0]       rem_next;

	assign take     = start && (state_q == S_IDLE);
	assign rem_next = rem_q >> 1;

	// Multiplier launches:
	//  - from CHECK: acc*sq when the low bit is set, else sq*sq
	//  - from MUL done: sq*sq while higher exponent bits remain
	always_comb begin
		mul_go = 1'b0;
		mul_a  = sq_q;
		case (state_q)
			S_CHECK: begin
				if (!neg_q && rem_q != '0) begin
					mul_go = 1'b1;
					mul_a  = rem_q[0] ? acc_q : sq_q;
				end
			end
			S_MUL: begin
				if (mul_done && rem_next != '0) begin
					mul_go = 1'b1;
				end
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	ipow_mul #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.op_a   (mul_a),
		.op_b   (sq_q),
		.done   (mul_done),
		.product(mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (neg_q || rem_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (rem_q[0]) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= (rem_next != '0) ? S_SQR : S_CHECK;
					end
				end
				S_SQR: begin
					if (mul_done) begin
						state_q <= S_CHECK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			neg_q <= exponent[EXPONENT_WIDTH-1];
			acc_q <= VALUE_WIDTH'(1);
			sq_q  <= base_value;
			rem_q <= exponent[REM_W-1:0];
		end
		// a clear bit drops out as the square launches
		if (state_q == S_CHECK && !neg_q && rem_q != '0 && !rem_q[0]) begin
			rem_q <= rem_next;
		end
		if (state_q == S_MUL && mul_done) begin
			acc_q <= mul_prod;
			rem_q <= rem_next;
		end
		if (state_q == S_SQR && mul_done) begin
			sq_q <= mul_prod;
		end
		if (state_q == S_CHECK && (neg_q || rem_q == '0)) begin
			result_q <= neg_q ? '0 : acc_q;
			status_q <= neg_q ? STATUS_INVALID : STATUS_OK;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign power_result = result_q;
	assign status       = status_q;

	// result strobe only follows the final decision cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_CHECK))
		else $error("result strobe without final check");

	// a rejected request always reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_INVALID) |-> (power_result == '0))
		else $error("invalid status with nonzero result");

	// multiplier only finishes while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL || state_q == S_SQR))
		else $error("multiplier done outside a product phase");

	// a taken request always moves to the decision cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_CHECK))
		else $error("request taken but sequencer did not start");

	// no two multiplier launches back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_go |=> !mul_go)
		else $error("back-to-back multiplier launch");

endmodule
